### rtl/egcd_pkg.sv
// shared constants and types for the extended gcd solver
// no dependencies
package egcd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned WideWidth = 64;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [WideWidth-1:0] wide_t;

  // request to the shared divider, and its reply
  typedef struct packed {
    logic  start;
    wide_t dividend;
    wide_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    wide_t quotient;
    wide_t remainder;
  } div_rsp_t;

endpackage

### rtl/egcd_divider.sv
// shared radix-2 signed divider, truncating quotient and remainder
// depends on egcd_pkg
module egcd_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  egcd_pkg::div_req_t  req_i,
  output egcd_pkg::div_rsp_t  rsp_o
);
  import egcd_pkg::*;

  localparam int unsigned CntW = $clog2(WideWidth);

  logic [WideWidth-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic                 neg_q_q, neg_q_d, neg_r_q, neg_r_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WideWidth:0]   trial;
  logic [WideWidth-1:0] shifted;

  always_comb begin
    shifted = {rem_q[WideWidth-2:0], quo_q[WideWidth-1]};
    trial   = {1'b0, shifted} - {1'b0, dsr_q};
  end

  // one quotient bit per cycle over magnitudes
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dsr_d = dsr_q;
    neg_q_d = neg_q_q; neg_r_d = neg_r_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d   = '0;
      quo_d   = req_i.dividend[WideWidth-1] ? -req_i.dividend : req_i.dividend;
      dsr_d   = req_i.divisor[WideWidth-1] ? -req_i.divisor : req_i.divisor;
      neg_q_d = req_i.dividend[WideWidth-1] ^ req_i.divisor[WideWidth-1];
      neg_r_d = req_i.dividend[WideWidth-1];
      busy_d  = 1'b1;
      cnt_d   = '0;
    end else if (busy_q) begin
      if (!trial[WideWidth]) begin
        rem_d = trial[WideWidth-1:0];
        quo_d = {quo_q[WideWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[WideWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WideWidth-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dsr_q <= dsr_d;
    neg_q_q <= neg_q_d; neg_r_q <= neg_r_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = neg_q_q ? -quo_q : quo_q;
  assign rsp_o.remainder = neg_r_q ? -rem_q : rem_q;

endmodule

### rtl/egcd_mac.sv
// shared multiply-subtract unit: acc - m1*m2, one partial product per cycle
// depends on egcd_pkg
module egcd_mac (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  egcd_pkg::wide_t acc_i,
  input  egcd_pkg::wide_t mul_a_i,
  input  egcd_pkg::wide_t mul_b_i,
  output logic            done_o,
  output egcd_pkg::wide_t result_o
);
  import egcd_pkg::*;

  // three 32x32 partial products form the low 64 bits; the product of the high halves is dropped
  localparam int unsigned HalfW = WideWidth / 2;

  logic [1:0]           step_q;
  logic                 busy_q, done_q;
  logic [WideWidth-1:0] a_q, b_q, sum_q;
  logic [HalfW-1:0]     pa, pb;
  logic [WideWidth-1:0] prod, term;

  always_comb begin
    pa   = step_q[0] ? a_q[WideWidth-1:HalfW] : a_q[HalfW-1:0];
    pb   = step_q[1] ? b_q[WideWidth-1:HalfW] : b_q[HalfW-1:0];
    prod = {{HalfW{1'b0}}, pa} * {{HalfW{1'b0}}, pb};
    case (step_q)
      2'd0:    term = prod;
      2'd1,
      2'd2:    term = {prod[HalfW-1:0], {HalfW{1'b0}}};
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= mul_a_i;
      b_q   <= mul_b_i;
      sum_q <= acc_i;
    end else if (busy_q) begin
      sum_q <= sum_q - term;
    end
  end

  assign done_o   = done_q;
  assign result_o = sum_q;

endmodule

### rtl/extended_gcd_diophantine_solver_core.sv
// Extended Euclidean solver for a*x+b*y=c on signed 32-bit requests.
// One request at a time: stall_o stays high from acceptance until the result is taken. Each
// Euclid step takes one pass of the shared bit-serial divider plus two multiply-subtract
// passes; the final solution costs one divide for the divisibility test when the gcd is
// nonzero and, when that test passes, two multiplies and two divides for the scaled values.
// depends on egcd_pkg, egcd_divider, egcd_mac
module extended_gcd_diophantine_solver_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  egcd_pkg::data_t       value_a_i,
  input  egcd_pkg::data_t       value_b_i,
  input  egcd_pkg::data_t       target_c_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output egcd_pkg::data_t       gcd_value_o,
  output egcd_pkg::data_t       coef_x_o,
  output egcd_pkg::data_t       coef_y_o,
  output logic                  solvable_o,
  output egcd_pkg::wide_t       solution_x_o,
  output egcd_pkg::wide_t       solution_y_o
);
  import egcd_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StMulS  = 4'd2;
  localparam logic [3:0] StMulT  = 4'd3;
  localparam logic [3:0] StChk   = 4'd4;
  localparam logic [3:0] StChkW  = 4'd5;
  localparam logic [3:0] StMx    = 4'd6;
  localparam logic [3:0] StDx    = 4'd7;
  localparam logic [3:0] StMy    = 4'd8;
  localparam logic [3:0] StDy    = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;

  logic [3:0] state_q, state_d;
  wide_t ra_q, rb_q, s1_q, s2_q, t1_q, t2_q, c_q, q_q, r_q, solx_q, soly_q;
  wide_t dw, xw, yw;
  logic  ok_q;
  logic  launch_div, launch_mac;
  wide_t div_num, div_den, mac_acc, mac_a, mac_b, mac_res;
  logic  mac_done;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // reported values wrapped to operand width
  assign dw = WideWidth'(signed'(ra_q[DataWidth-1:0]));
  assign xw = WideWidth'(signed'(s1_q[DataWidth-1:0]));
  assign yw = WideWidth'(signed'(t1_q[DataWidth-1:0]));

  assign div_req.start    = launch_div;
  assign div_req.dividend = div_num;
  assign div_req.divisor  = div_den;

  egcd_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  egcd_mac u_mac (
    .clk_i, .rst_ni, .start_i(launch_mac), .acc_i(mac_acc), .mul_a_i(mac_a),
    .mul_b_i(mac_b), .done_o(mac_done), .result_o(mac_res)
  );

  // sequencer: picks operands for the shared units
  always_comb begin
    state_d = state_q;
    launch_div = 1'b0; launch_mac = 1'b0;
    div_num = ra_q; div_den = rb_q;
    mac_acc = s1_q; mac_a = q_q; mac_b = s2_q;
    case (state_q)
      StIdle: if (valid_i) begin
        state_d = StChk;
        if (value_a_i != '0 && value_b_i != '0) begin
          state_d = StDiv;
          launch_div = 1'b1;
          div_num = WideWidth'(value_a_i);
          div_den = WideWidth'(value_b_i);
        end
      end
      StDiv: if (div_rsp.done) begin
        state_d = StMulS; launch_mac = 1'b1;
        mac_a = div_rsp.quotient;
      end
      StMulS: if (mac_done) begin
        state_d = StMulT; launch_mac = 1'b1;
        mac_acc = t1_q; mac_b = t2_q;
      end
      StMulT: if (mac_done) begin
        if (r_q == '0) state_d = StChk;
        else begin
          state_d = StDiv; launch_div = 1'b1;
          div_num = rb_q; div_den = r_q;
        end
      end
      StChk: begin
        if (dw == '0) state_d = StOut;
        else begin
          state_d = StChkW; launch_div = 1'b1;
          div_num = c_q; div_den = dw;
        end
      end
      StChkW: if (div_rsp.done) begin
        if (div_rsp.remainder != '0) state_d = StOut;
        else begin
          state_d = StMx; launch_mac = 1'b1;
          mac_acc = '0; mac_a = xw; mac_b = -c_q;
        end
      end
      StMx: if (mac_done) begin
        state_d = StDx; launch_div = 1'b1;
        div_num = mac_res; div_den = dw;
      end
      StDx: if (div_rsp.done) begin
        state_d = StMy; launch_mac = 1'b1;
        mac_acc = '0; mac_a = yw; mac_b = -c_q;
      end
      StMy: if (mac_done) begin
        state_d = StDy; launch_div = 1'b1;
        div_num = mac_res; div_den = dw;
      end
      StDy: if (div_rsp.done) state_d = StOut;
      StOut: if (!stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (valid_i) begin
        c_q <= WideWidth'(target_c_i);
        ok_q <= 1'b0; solx_q <= '0; soly_q <= '0;
        if (value_b_i == '0) begin
          ra_q <= WideWidth'(value_a_i); s1_q <= 64'sd1; t1_q <= '0;
        end else if (value_a_i == '0) begin
          ra_q <= WideWidth'(value_b_i); s1_q <= '0; t1_q <= 64'sd1;
        end else begin
          ra_q <= WideWidth'(value_a_i); rb_q <= WideWidth'(value_b_i);
          s1_q <= 64'sd1; s2_q <= '0; t1_q <= '0; t2_q <= 64'sd1;
        end
      end
      StDiv: if (div_rsp.done) begin
        q_q <= div_rsp.quotient; r_q <= div_rsp.remainder;
      end
      StMulS: if (mac_done) begin
        s1_q <= s2_q; s2_q <= mac_res;
      end
      StMulT: if (mac_done) begin
        t1_q <= t2_q; t2_q <= mac_res;
        ra_q <= rb_q; rb_q <= r_q;
      end
      StChk: if (dw == '0) ok_q <= (c_q == '0);
      StChkW: if (div_rsp.done) ok_q <= (div_rsp.remainder == '0);
      StDx: if (div_rsp.done) solx_q <= div_rsp.quotient;
      StDy: if (div_rsp.done) soly_q <= div_rsp.quotient;
      default: ;
    endcase
  end

  assign stall_o      = (state_q != StIdle);
  assign valid_o      = (state_q == StOut);
  assign gcd_value_o  = dw[DataWidth-1:0];
  assign coef_x_o     = xw[DataWidth-1:0];
  assign coef_y_o     = yw[DataWidth-1:0];
  assign solvable_o   = ok_q;
  assign solution_x_o = solx_q;
  assign solution_y_o = soly_q;

endmodule

### test/egcd_checker.sv
`timescale 1ns / 100ps
// checker for the extended gcd solver: watches both channels and predicts each result
// depends on egcd_pkg
module egcd_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            stall_o,
  input  egcd_pkg::data_t value_a_i,
  input  egcd_pkg::data_t value_b_i,
  input  egcd_pkg::data_t target_c_i,
  input  logic            valid_o,
  input  logic            stall_i,
  input  egcd_pkg::data_t gcd_value_o,
  input  egcd_pkg::data_t coef_x_o,
  input  egcd_pkg::data_t coef_y_o,
  input  logic            solvable_o,
  input  egcd_pkg::wide_t solution_x_o,
  input  egcd_pkg::wide_t solution_y_o,
  output int              fail_count_o,
  output int              pending_o,
  output int              solved_count_o
);
  import egcd_pkg::*;

  typedef struct packed {
    data_t gcd;
    data_t cx;
    data_t cy;
    logic  ok;
    wide_t sx;
    wide_t sy;
  } answer_t;

  answer_t answer_q[$];

  // extended euclid with truncating division at 64 bits
  function automatic answer_t solve_diophantine(data_t a, data_t b, data_t c);
    answer_t res;
    longint ra, rb, s1, s2, t1, t2, q, r, s, t, d, x, y, cw;
    ra = a; rb = b; cw = c;
    if (rb == 0) begin
      d = ra; x = 1; y = 0;
    end else if (ra == 0) begin
      d = rb; x = 0; y = 1;
    end else begin
      s1 = 1; s2 = 0; t1 = 0; t2 = 1;
      while (rb != 0) begin
        q = ra / rb; r = ra % rb;
        s = s1 - q * s2; t = t1 - q * t2;
        ra = rb; rb = r; s1 = s2; s2 = s; t1 = t2; t2 = t;
      end
      d = ra; x = s1; y = t1;
    end
    res.gcd = data_t'(d);
    res.cx = data_t'(x);
    res.cy = data_t'(y);
    res.sx = '0;
    res.sy = '0;
    if (res.gcd == 0) begin
      res.ok = (cw == 0);
    end else if (cw % longint'(res.gcd) != 0) begin
      res.ok = 1'b0;
    end else begin
      res.ok = 1'b1;
      res.sx = (longint'(res.cx) * cw) / longint'(res.gcd);
      res.sy = (longint'(res.cy) * cw) / longint'(res.gcd);
    end
    return res;
  endfunction

  assign pending_o = answer_q.size();

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
      solved_count_o <= 0;
    end else begin
      if (valid_i && !stall_o)
        answer_q.insert(answer_q.size(), solve_diophantine(value_a_i, value_b_i, target_c_i));
      if (valid_o && !stall_i) begin
        if (answer_q.size() == 0) begin
          $error("result with no request pending");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = answer_q.pop_front();
          if (exp_r.ok) solved_count_o <= solved_count_o + 1;
          if (gcd_value_o !== exp_r.gcd || coef_x_o !== exp_r.cx ||
              coef_y_o !== exp_r.cy || solvable_o !== exp_r.ok ||
              solution_x_o !== exp_r.sx || solution_y_o !== exp_r.sy)
            fail_count_o <= fail_count_o + 1;
          if (gcd_value_o !== exp_r.gcd)
            $error("gcd_value expected %0d got %0d", exp_r.gcd, gcd_value_o);
          if (coef_x_o !== exp_r.cx)
            $error("coef_x expected %0d got %0d", exp_r.cx, coef_x_o);
          if (coef_y_o !== exp_r.cy)
            $error("coef_y expected %0d got %0d", exp_r.cy, coef_y_o);
          if (solvable_o !== exp_r.ok)
            $error("solvable expected %0d got %0d", exp_r.ok, solvable_o);
          if (solution_x_o !== exp_r.sx)
            $error("solution_x expected %0d got %0d", exp_r.sx, solution_x_o);
          if (solution_y_o !== exp_r.sy)
            $error("solution_y expected %0d got %0d", exp_r.sy, solution_y_o);
        end
      end
    end
  end

endmodule

### test/tb_extended_gcd_diophantine_solver_core.sv
`timescale 1ns / 100ps
// stimulus and verdict for the extended gcd solver
// depends on egcd_pkg, extended_gcd_diophantine_solver_core, egcd_checker
module tb_extended_gcd_diophantine_solver_core;
  import egcd_pkg::*;

  localparam int MaxCycles = 8000000;
  localparam data_t MaxPos = 32'sh7fffffff;
  localparam data_t MinOk = -32'sh7fffffff;

  logic clk_i, rst_ni, valid_i, stall_o, valid_o, stall_i, solvable_o;
  data_t value_a_i, value_b_i, target_c_i, gcd_value_o, coef_x_o, coef_y_o;
  wide_t solution_x_o, solution_y_o;
  int fail_count, pending, solved_count, cycle_count, sent_count;
  int send_idle_pct, recv_idle_pct, hold_cycles;

  extended_gcd_diophantine_solver_core DUT (.*);

  egcd_checker u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending), .solved_count_o(solved_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > MaxCycles) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver stall: random, or a long hold-off when hold_cycles is set
  initial begin
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic data_t rand_operand();
    data_t v;
    case ($urandom_range(5))
      0: v = data_t'($urandom_range(20)) - 10;
      1: v = data_t'($urandom_range(2000)) - 1000;
      2: v = MaxPos - data_t'($urandom_range(3));
      3: v = MinOk + data_t'($urandom_range(3));
      default: v = data_t'($urandom());
    endcase
    if (v == 32'sh80000000) v = MinOk;
    return v;
  endfunction

  // valid drops only during idle gaps, so back to back requests keep it high
  task automatic send_request(data_t a, data_t b, data_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    value_a_i <= a;
    value_b_i <= b;
    target_c_i <= c;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  // random request, often built so that d divides c
  task automatic send_random();
    data_t a, b, c, k;
    a = rand_operand();
    b = rand_operand();
    if ($urandom_range(1)) begin
      k = data_t'($urandom_range(200)) - 100;
      c = data_t'(longint'(a) * k);
      if (c == 32'sh80000000) c = MinOk;
    end else begin
      c = rand_operand();
    end
    send_request(a, b, c);
  endtask

  initial begin
    data_t edge_v[7];
    rst_ni = 1'b0;
    valid_i = 1'b0;
    value_a_i = '0;
    value_b_i = '0;
    target_c_i = '0;
    sent_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zeros, extremes, coprime, non-divisible
    edge_v = '{0, 1, -1, MaxPos, MinOk, 12, -18};
    send_request(0, 0, 0);
    send_request(0, 0, 5);
    send_request(7, 0, 14);
    send_request(0, -9, 3);
    send_request(12, 18, 7);
    send_request(MaxPos, MaxPos - 1, MinOk);
    send_request(MinOk, MaxPos, MaxPos);
    for (int i = 0; i < 16; i++)
      send_request(edge_v[$urandom_range(6)], edge_v[$urandom_range(6)],
                   edge_v[$urandom_range(6)]);

    // phase 1: sender idles less, receiver more
    send_idle_pct = 33; recv_idle_pct = 57;
    repeat (130) send_random();
    // long receiver hold-off while requests keep coming
    hold_cycles = 8000;
    repeat (3) send_random();
    // sender waits until everything is back
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    send_idle_pct = 57; recv_idle_pct = 33;
    repeat (130) send_random();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (130) send_random();

    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("sent %0d requests with edge operands and random gaps, %0d solvable",
             sent_count, solved_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/egcd_pkg.sv
rtl/egcd_divider.sv
rtl/egcd_mac.sv
rtl/extended_gcd_diophantine_solver_core.sv
test/egcd_checker.sv
test/tb_extended_gcd_diophantine_solver_core.sv
